>>> rtl/kmst_pkg.sv
package kmst_pkg;
  localparam int MAX_NODES_DEF   = 64;
  localparam int MAX_EDGES_DEF   = 2048;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam int NODE_W          = 6;
  localparam int IN_WEIGHT_W     = 16;
  localparam int TOTAL_W         = 22;
endpackage

>>> rtl/kmst_if.sv
interface kmst_edge_if;
  import kmst_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [NODE_W-1:0]      from_node;
  logic [NODE_W-1:0]      to_node;
  logic [IN_WEIGHT_W-1:0] edge_weight;
  logic                   last_edge;
  modport source(output valid, from_node, to_node, edge_weight, last_edge, input ready);
  modport sink(input valid, from_node, to_node, edge_weight, last_edge, output ready);
endinterface

interface kmst_total_if;
  import kmst_pkg::*;
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] total_weight;
  logic               overflow;
  modport source(output valid, total_weight, overflow, input ready);
  modport sink(input valid, total_weight, overflow, output ready);
endinterface

>>> rtl/kmst_ram.sv
module kmst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/kruskal_mst_single_root_edge_top.sv
// Minimum spanning weight with a single root edge.
// The edge_in channel takes one edge per request (from_node, to_node,
// edge_weight, last_edge). Edges are stored one per cycle while the block
// is loading. The request with last_edge set starts the run: the stored
// edges are ordered by ascending weight with an insertion sort over the
// edge memory (about E*E/4 shifts on random weights, one read port), then
// scanned with a union-find whose find walks compress the path to the
// root. The result request on total_out carries total_weight (saturated
// at 2^22-1) and overflow, set if edges beyond MAX_EDGES were dropped.
// After the result is sent, parent and size tables are swept back to
// their initial values before the next edge is taken.
// Reset runs that same sweep first. A result waits in its output register
// while the receiver stalls; no new edge is taken meanwhile.
module kruskal_mst_single_root_edge_top
  import kmst_pkg::*;
#(
  parameter int MAX_NODES   = MAX_NODES_DEF,
  parameter int MAX_EDGES   = MAX_EDGES_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  kmst_edge_if.sink    edge_in,
  kmst_total_if.source total_out
);
  localparam int EA    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EC    = $clog2(MAX_EDGES + 1);
  localparam int NA    = $clog2(MAX_NODES);
  localparam int NC    = $clog2(MAX_NODES + 1);
  localparam int EW    = 2 * NODE_W + WEIGHT_BITS;
  localparam int SUM_W = TOTAL_W + 1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef enum logic [14:0] {
    S_CLEAR  = 15'd1,
    S_LOAD   = 15'd2,
    S_SINIT  = 15'd4,
    S_SREAD  = 15'd8,
    S_SCMP   = 15'd16,
    S_KREAD  = 15'd32,
    S_KEDGE  = 15'd64,
    S_FWALK  = 15'd128,
    S_FCOMP  = 15'd256,
    S_FCPRD  = 15'd512,
    S_DECIDE = 15'd1024,
    S_SZRD   = 15'd2048,
    S_UNION  = 15'd4096,
    S_OUT    = 15'd8192,
    S_SCUR   = 15'd16384
  } state_t;

  state_t state;

  // Edge memory.
  logic          e_we;
  logic [EA-1:0] e_waddr, e_raddr;
  logic [EW-1:0] e_wdata, e_rdata;
  kmst_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edges (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  // Parent and size tables.
  logic          p_we, s_we;
  logic [NA-1:0] p_waddr, p_raddr, s_waddr, s_raddr;
  logic [NA-1:0] p_wdata, p_rdata;
  logic [NC-1:0] s_wdata, s_rdata;
  kmst_ram #(.WIDTH(NA), .DEPTH(MAX_NODES)) u_parent (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );
  kmst_ram #(.WIDTH(NC), .DEPTH(MAX_NODES)) u_size (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  logic [EC-1:0]          count;
  logic                   dropped, root_free;
  logic [SUM_W-1:0]       sum;
  logic [NA-1:0]          clr_idx;
  logic [EC-1:0]          i_idx, j_idx;
  logic [EW-1:0]          cur;
  logic [NODE_W-1:0]      ea, eb;
  logic [WEIGHT_BITS-1:0] ew;
  logic [NA-1:0]          walk, node, ra, rb;
  logic                   fsecond;
  logic [NC-1:0]          size_a;
  logic [TOTAL_W-1:0]     out_total;
  logic                   out_ovf, out_valid;

  logic [WEIGHT_BITS-1:0] in_w, cur_w, rd_w;
  logic [NODE_W-1:0]      rd_a, rd_b;
  assign in_w  = WEIGHT_BITS'(edge_in.edge_weight);
  assign cur_w = cur[WEIGHT_BITS-1:0];
  assign rd_w  = e_rdata[WEIGHT_BITS-1:0];
  assign rd_a  = e_rdata[EW-1 -: NODE_W];
  assign rd_b  = e_rdata[WEIGHT_BITS +: NODE_W];

  logic [SUM_W-1:0] sum_add;
  assign sum_add = sum + SUM_W'(ew);

  logic load_take;
  assign load_take = (state == S_LOAD) && edge_in.valid;
  assign edge_in.ready = (state == S_LOAD);

  assign total_out.valid        = out_valid;
  assign total_out.total_weight = out_total;
  assign total_out.overflow     = out_ovf;

  // Start node of the current find: first ea then eb.
  logic [NA-1:0] fnode;
  assign fnode = fsecond ? NA'(eb) : NA'(ea);

  always_comb begin
    e_we = 1'b0; e_waddr = count[EA-1:0]; e_raddr = '0;
    e_wdata = {edge_in.from_node, edge_in.to_node, in_w};
    p_we = 1'b0; p_waddr = clr_idx; p_wdata = clr_idx; p_raddr = walk;
    s_we = 1'b0; s_waddr = clr_idx; s_wdata = NC'(1); s_raddr = ra;
    case (state)
      S_CLEAR: begin
        p_we = 1'b1; s_we = 1'b1;
      end
      S_LOAD: begin
        e_we = load_take && (32'(count) < MAX_EDGES);
      end
      S_SINIT: e_raddr = i_idx[EA-1:0];
      S_SREAD: e_raddr = EA'(j_idx - 1'b1);
      S_SCMP: begin
        // Shift the larger entry up one place.
        if (rd_w > cur_w) begin
          e_we = 1'b1; e_waddr = j_idx[EA-1:0]; e_wdata = e_rdata;
        end
      end
      S_SCUR: begin
        e_we = 1'b1; e_waddr = j_idx[EA-1:0]; e_wdata = cur;
      end
      S_KREAD: e_raddr = i_idx[EA-1:0];
      S_FCOMP: begin
        // Point node at the root and fetch the parent of the next node.
        p_we = 1'b1; p_waddr = node; p_wdata = walk; p_raddr = p_rdata;
      end
      S_FCPRD: p_raddr = fnode;
      S_SZRD: s_raddr = rb;
      S_UNION: begin
        p_we = 1'b1; s_we = 1'b1;
        if (size_a < s_rdata) begin
          p_waddr = ra; p_wdata = rb; s_waddr = rb;
        end else begin
          p_waddr = rb; p_wdata = ra; s_waddr = ra;
        end
        s_wdata = size_a + s_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; clr_idx <= '0; count <= '0; dropped <= 1'b0;
      root_free <= 1'b1; sum <= '0; out_valid <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (32'(clr_idx) == MAX_NODES - 1) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (edge_in.valid) begin
            if (32'(count) < MAX_EDGES) begin
              count <= count + 1'b1;
            end else begin
              dropped <= 1'b1;
            end
            if (edge_in.last_edge) begin
              i_idx <= EC'(1);
              state <= S_SINIT;
            end
          end
        end
        S_SINIT: begin
          if (i_idx >= count) begin
            i_idx <= '0; state <= S_KREAD;
          end else begin
            j_idx <= i_idx; state <= S_SREAD;
          end
        end
        S_SREAD: begin
          // Memory read of entry j-1 in flight; cur loads on first pass.
          if (j_idx == i_idx) begin
            cur <= e_rdata;
          end
          state <= S_SCMP;
        end
        S_SCMP: begin
          if (rd_w > cur_w) begin
            j_idx <= j_idx - 1'b1;
            state <= (j_idx == EC'(1)) ? S_SCUR : S_SREAD;
          end else begin
            state <= S_SCUR;
          end
        end
        S_SCUR: begin
          i_idx <= i_idx + 1'b1; state <= S_SINIT;
        end
        S_KREAD: begin
          if (i_idx >= count) begin
            out_total <= (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
            out_ovf <= dropped; out_valid <= 1'b1; state <= S_OUT;
          end else begin
            state <= S_KEDGE;
          end
        end
        S_KEDGE: begin
          ea <= rd_a; eb <= rd_b; ew <= rd_w; fsecond <= 1'b0;
          if ((32'(rd_a) < MAX_NODES) && (32'(rd_b) < MAX_NODES)) begin
            walk <= NA'(rd_a); state <= S_FWALK;
          end else begin
            i_idx <= i_idx + 1'b1; state <= S_KREAD;
          end
        end
        S_FWALK: begin
          // Parent of walk is read here; p_rdata holds it in S_FCPRD.
          state <= S_FCPRD;
        end
        S_FCPRD: begin
          if (p_rdata == walk) begin
            node <= fnode; state <= S_FCOMP;
            if (fsecond) rb <= walk; else ra <= walk;
          end else begin
            walk <= p_rdata; state <= S_FWALK;
          end
        end
        S_FCOMP: begin
          // Walk from the start node, pointing each step at the root.
          if (node == walk) begin
            if (!fsecond) begin
              fsecond <= 1'b1; walk <= NA'(eb); state <= S_FWALK;
            end else begin
              state <= S_DECIDE;
            end
          end else begin
            node <= p_rdata;
            state <= S_FCOMP;
          end
        end
        S_DECIDE: begin
          if (ra == rb ||
              (((ea == '0) || (eb == '0)) && !root_free)) begin
            i_idx <= i_idx + 1'b1; state <= S_KREAD;
          end else begin
            if ((ea == '0) || (eb == '0)) root_free <= 1'b0;
            state <= S_SZRD;
          end
        end
        S_SZRD: begin
          size_a <= s_rdata; state <= S_UNION;
        end
        S_UNION: begin
          sum <= (sum_add > SUM_W'(TOTAL_MAX)) ? SUM_W'(TOTAL_MAX) : sum_add;
          i_idx <= i_idx + 1'b1; state <= S_KREAD;
        end
        S_OUT: begin
          if (total_out.ready) begin
            out_valid <= 1'b0; count <= '0; dropped <= 1'b0; root_free <= 1'b1;
            sum <= '0; clr_idx <= '0; state <= S_CLEAR;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  a_ready_load: assert property (@(posedge clk) disable iff (rst)
    edge_in.ready |-> !out_valid) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !total_out.ready |=> out_valid && $stable(out_total))
    else $error("result dropped");
  a_root_once: assert property (@(posedge clk) disable iff (rst)
    $fell(root_free) |-> state == S_SZRD) else $error("root flag misuse");
endmodule
